@@ rtl/mlgb_pkg.sv @@
`timescale 1ns / 1ps

package mlgb_pkg;

	localparam int MLGB_MAX_RADIUS = 63;
	localparam int MLGB_MAX_LINE   = 4096;

	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_PIXEL  = 1'b1;

	// Register index as decoded from paddr[2].
	localparam logic REG_RADIUS = 1'b0;

	typedef struct packed {
		logic        opcode;
		logic [5:0]  weight_index;
		logic [15:0] weight;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        is_target;
		logic        last_in_line;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       out_target;
		logic       line_end;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SETUP,
		ST_READ,
		ST_ACC,
		ST_DIV_INIT,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_CENTER,
		PH_LEFT,
		PH_RIGHT
	} tap_phase_t;

	typedef struct packed {
		logic wr_weight;
		logic wr_pixel;
		logic setup;
		logic capture;
		logic acc;
		logic step_left;
		logic to_right;
		logic step_right;
		logic div_start;
		logic div_step;
		logic out_load;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic more;
		logic pix_tgt;
		logic left_zero;
		logic right_zero;
		logic left_end;
		logic right_end;
		logic div_last;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/mlgb_ram.sv @@
`timescale 1ns / 1ps

module mlgb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/mlgb_ctrl.sv @@
`timescale 1ns / 1ps

module mlgb_ctrl
	import mlgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_opcode,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       item_stall
);

	state_t     state_q, state_d;
	tap_phase_t phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_CENTER;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					if (item_opcode == OP_PIXEL) begin
						cmd.wr_pixel = 1'b1;
						state_d      = ST_CHECK;
					end else begin
						cmd.wr_weight = 1'b1;
					end
				end
			end
			ST_CHECK: begin
				if (status.more) begin
					state_d = ST_SETUP;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				phase_d   = PH_CENTER;
				state_d   = ST_READ;
			end
			ST_READ: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				unique case (phase_q)
					PH_CENTER: begin
						cmd.capture = 1'b1;
						if (!status.pix_tgt) begin
							state_d = ST_OUT;
						end else begin
							cmd.acc = 1'b1;
							if (!status.left_zero) begin
								cmd.step_left = 1'b1;
								phase_d       = PH_LEFT;
								state_d       = ST_READ;
							end else if (!status.right_zero) begin
								cmd.to_right = 1'b1;
								phase_d      = PH_RIGHT;
								state_d      = ST_READ;
							end else begin
								state_d = ST_DIV_INIT;
							end
						end
					end
					PH_LEFT: begin
						cmd.acc = status.pix_tgt;
						if (status.pix_tgt && !status.left_end) begin
							cmd.step_left = 1'b1;
							state_d       = ST_READ;
						end else if (!status.right_zero) begin
							cmd.to_right = 1'b1;
							phase_d      = PH_RIGHT;
							state_d      = ST_READ;
						end else begin
							state_d = ST_DIV_INIT;
						end
					end
					PH_RIGHT: begin
						cmd.acc = status.pix_tgt;
						if (status.pix_tgt && !status.right_end) begin
							cmd.step_right = 1'b1;
							state_d        = ST_READ;
						end else begin
							state_d = ST_DIV_INIT;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_DIV_INIT: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/mlgb_datapath.sv @@
`timescale 1ns / 1ps

module mlgb_datapath
	import mlgb_pkg::*;
#(
	parameter int MAX_RADIUS = MLGB_MAX_RADIUS,
	parameter int MAX_LINE   = MLGB_MAX_LINE
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	input  in_item_t   item,
	input  logic [5:0] radius,
	output out_item_t  result,
	output logic       result_valid,
	input  logic       result_stall
);

	localparam int WIN = 2 * MAX_RADIUS + 1;
	localparam int WAW = $clog2(WIN);
	localparam int RW  = $clog2(MAX_RADIUS + 1);
	localparam int PW  = $clog2(MAX_RADIUS + 2);
	localparam int LPW = $clog2(MAX_LINE + 1);
	localparam int XW  = LPW + PW + RW;
	localparam int EW  = (RW > 6) ? RW : 6;
	localparam int CW  = 16 + $clog2(WIN + 1);
	localparam int SW  = CW + 8;
	localparam int NW  = SW + 1;

	// Window and weight memories.
	logic [24:0]    win_rdata;
	logic [15:0]    w_rdata;
	logic [WAW-1:0] wr_idx_q;
	logic [WAW-1:0] tp_q;
	logic [RW-1:0]  k_q;
	logic [RW+5:0]  wi_ext;
	logic           w_we;

	assign wi_ext = (RW + 6)'(item.weight_index);
	assign w_we   = cmd.wr_weight && (wi_ext <= (RW + 6)'(MAX_RADIUS));

	mlgb_ram #(.WIDTH(25), .DEPTH(WIN)) u_win (
		.clk     (clk),
		.wr_en   (cmd.wr_pixel),
		.wr_addr (wr_idx_q),
		.wr_data ({item.is_target, item.blue, item.green, item.red}),
		.rd_addr (tp_q),
		.rd_data (win_rdata)
	);

	mlgb_ram #(.WIDTH(16), .DEPTH(MAX_RADIUS + 1)) u_wgt (
		.clk     (clk),
		.wr_en   (w_we),
		.wr_addr (wi_ext[RW-1:0]),
		.wr_data (item.weight),
		.rd_addr (k_q),
		.rd_data (w_rdata)
	);

	// Line bookkeeping.
	logic [LPW-1:0] line_pos_q;
	logic [PW-1:0]  pending_q;
	logic           last_q;
	logic [WAW-1:0] c_idx_q;
	logic [RW-1:0]  left_q, right_q;
	logic           end_q;

	logic [EW-1:0]  rad_ext;
	logic [RW-1:0]  r_eff;
	logic [LPW-1:0] c_pos;
	logic [PW-1:0]  pm1;
	logic [WAW:0]   c_idx_w;
	logic [RW-1:0]  left_d, right_d;

	assign rad_ext = EW'(radius);
	assign r_eff   = (rad_ext > EW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : rad_ext[RW-1:0];
	assign c_pos   = line_pos_q - LPW'(pending_q);
	assign pm1     = pending_q - PW'(1);
	assign left_d  = (XW'(c_pos) > XW'(r_eff)) ? r_eff : c_pos[RW-1:0];
	assign right_d = (XW'(pm1) > XW'(r_eff)) ? r_eff : pm1[RW-1:0];

	always_comb begin
		if ((WAW + 1)'(wr_idx_q) >= (WAW + 1)'(pending_q)) begin
			c_idx_w = (WAW + 1)'(wr_idx_q) - (WAW + 1)'(pending_q);
		end else begin
			c_idx_w = (WAW + 1)'(wr_idx_q) + (WAW + 1)'(WIN) - (WAW + 1)'(pending_q);
		end
	end

	function automatic logic [WAW-1:0] ring_inc(input logic [WAW-1:0] p);
		ring_inc = (p == WAW'(WIN - 1)) ? '0 : p + WAW'(1);
	endfunction

	function automatic logic [WAW-1:0] ring_dec(input logic [WAW-1:0] p);
		ring_dec = (p == '0) ? WAW'(WIN - 1) : p - WAW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pos_q <= '0;
			wr_idx_q   <= '0;
			pending_q  <= '0;
			last_q     <= 1'b0;
		end else begin
			if (cmd.wr_pixel) begin
				line_pos_q <= line_pos_q + LPW'(1);
				wr_idx_q   <= ring_inc(wr_idx_q);
				pending_q  <= pending_q + PW'(1);
				last_q     <= item.last_in_line || (line_pos_q == LPW'(MAX_LINE - 1));
			end
			if (cmd.setup) begin
				pending_q <= pm1;
			end
			if (cmd.finish && last_q) begin
				line_pos_q <= '0;
				wr_idx_q   <= '0;
				pending_q  <= '0;
			end
		end
	end

	// Tap walk: center first, then leftward, then rightward.
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			c_idx_q <= c_idx_w[WAW-1:0];
			tp_q    <= c_idx_w[WAW-1:0];
			k_q     <= '0;
			left_q  <= left_d;
			right_q <= right_d;
			end_q   <= last_q && (pending_q == PW'(1));
		end else if (cmd.step_left) begin
			tp_q <= ring_dec(tp_q);
			k_q  <= k_q + RW'(1);
		end else if (cmd.to_right) begin
			tp_q <= ring_inc(c_idx_q);
			k_q  <= RW'(1);
		end else if (cmd.step_right) begin
			tp_q <= ring_inc(tp_q);
			k_q  <= k_q + RW'(1);
		end
	end

	// Weighted sums and divider.
	logic [SW-1:0] s_q [3];
	logic [CW-1:0] cs_q;
	logic [24:0]   ctr_q;
	logic [NW-1:0] rem_q [3];
	logic [7:0]    quo_q [3];
	logic [2:0]    bit_q;
	logic [23:0]   prod [3];
	logic [NW-1:0] trial;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch] = win_rdata[8*ch +: 8] * w_rdata;
		end
	end

	assign trial = NW'({cs_q, 1'b0}) << bit_q;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			for (int ch = 0; ch < 3; ch++) begin
				s_q[ch] <= '0;
			end
			cs_q <= '0;
		end else if (cmd.acc) begin
			for (int ch = 0; ch < 3; ch++) begin
				s_q[ch] <= s_q[ch] + SW'(prod[ch]);
			end
			cs_q <= cs_q + CW'(w_rdata);
		end
		if (cmd.capture) begin
			ctr_q <= win_rdata;
		end
		// Quotient always fits in eight bits since every sum is at most 255 times the weight total.
		if (cmd.div_start) begin
			for (int ch = 0; ch < 3; ch++) begin
				rem_q[ch] <= {s_q[ch], 1'b0} + NW'(cs_q);
				quo_q[ch] <= '0;
			end
			bit_q <= 3'd7;
		end else if (cmd.div_step) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (rem_q[ch] >= trial) begin
					rem_q[ch]        <= rem_q[ch] - trial;
					quo_q[ch][bit_q] <= 1'b1;
				end
			end
			bit_q <= bit_q - 3'd1;
		end
	end

	// Output register.
	logic      out_valid_q;
	out_item_t out_q;
	logic      pass;

	assign pass = !ctr_q[24] || (cs_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.out_red    <= pass ? ctr_q[7:0] : quo_q[0];
			out_q.out_green  <= pass ? ctr_q[15:8] : quo_q[1];
			out_q.out_blue   <= pass ? ctr_q[23:16] : quo_q[2];
			out_q.out_target <= ctr_q[24];
			out_q.line_end   <= end_q;
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

	assign status.more       = last_q ? (pending_q != '0) : (XW'(pending_q) > XW'(r_eff));
	assign status.pix_tgt    = win_rdata[24];
	assign status.left_zero  = (left_q == '0);
	assign status.right_zero = (right_q == '0);
	assign status.left_end   = (k_q == left_q);
	assign status.right_end  = (k_q == right_q);
	assign status.div_last   = (bit_q == 3'd0);
	assign status.out_free   = !out_valid_q || !result_stall;

endmodule

@@ rtl/masked_line_gaussian_blur.sv @@
`timescale 1ns / 1ps

// Masked 1-D Gaussian blur over a streamed line of RGB pixels. Weight beats
// are taken whenever the block is idle. A pixel beat is taken and then the
// block holds item_stall high while it produces the results that pixel
// releases (none, or up to the whole pending tail of the line when
// last_in_line is set). Each result reads T window taps (1 up to
// 2*radius + 1) one at a time from the window memory, which has a registered
// read, and then the rounding division runs one quotient bit per cycle for
// eight quotient bits. A non-target pixel skips the tap loop and the division.
// The block checks once more for an owed result before the next beat is taken.
// Results wait in an output register, so a result held by result_stall does
// not stop the next pixel beat from being taken.
module masked_line_gaussian_blur
	import mlgb_pkg::*;
#(
	parameter int MAX_RADIUS = MLGB_MAX_RADIUS,
	parameter int MAX_LINE   = MLGB_MAX_LINE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  in_item_t    item,
	output logic        result_valid,
	input  logic        result_stall,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [5:0] radius_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_RADIUS)) begin
			radius_q <= pwdata[5:0];
		end
	end

	assign prdata = (paddr[2] == REG_RADIUS) ? {26'd0, radius_q} : 32'd0;

	dp_cmd_t    cmd;
	dp_status_t status;

	mlgb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_opcode (item.opcode),
		.status      (status),
		.cmd         (cmd),
		.item_stall  (item_stall)
	);

	mlgb_datapath #(
		.MAX_RADIUS (MAX_RADIUS),
		.MAX_LINE   (MAX_LINE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item         (item),
		.radius       (radius_q),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	// A result is never written over one that still waits.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.out_load |-> status.out_free)
		else $error("result register overwritten");

	// Only target taps enter the weighted sums.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.acc |-> status.pix_tgt)
		else $error("non-target tap accumulated");

	// A new result is only started while one is still owed.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.setup |-> $past(status.more))
		else $error("result started with nothing pending");

endmodule
